// ----- src/hvab_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hough vote accumulator package
// Shared types, item layouts, function codes and default parameter values.
// ----------------------------------------------------------------------------
package hvab_pkg;

    localparam int VOTE_BOUND_DEF   = 50;
    localparam int BLOOM_RADIUS_DEF = 2;
    localparam int CELL_W           = 16;
    localparam int COORD_W          = 12;
    localparam int INDEX_W          = 7;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_VOTE  = 2'd1,
        FUNC_READ  = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_VOTE,
        ST_TAIL,
        ST_READ,
        ST_READ_DATA,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [COORD_W-1:0] scan_x;
        logic signed [COORD_W-1:0] scan_y;
        logic signed [COORD_W-1:0] tmpl_x;
        logic signed [COORD_W-1:0] tmpl_y;
        logic [INDEX_W-1:0]        read_row;
        logic [INDEX_W-1:0]        read_col;
    } t_in_item;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic              vote_taken;
    } t_out_item;

endpackage
`default_nettype wire

// ----- src/hvab_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hough vote accumulator input channel
// Valid/ready channel carrying one command item per transaction.
// ----------------------------------------------------------------------------
interface hvab_in_if;
    import hvab_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/hvab_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hough vote accumulator result channel
// Valid/ready channel carrying one result item per transaction.
// ----------------------------------------------------------------------------
interface hvab_out_if;
    import hvab_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/hough_vote_accumulator_bloom_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hough vote accumulator with square bloom
// Square grid of 16-bit vote cells in one RAM, with clear, vote and read.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                        Handshake
//  i_in     in   func, scan_x/y, tmpl_x/y, read_row, read_col   valid/ready
//  o_out    out  cell_value, vote_taken                         valid/ready
//
//  From acceptance to the next acceptance, a vote inside the bound runs an
//  address multiply, (2*BLOOM_RADIUS+1)^2 read-modify-write slots on the RAM
//  (one cell a cycle), one write tail and a result step. A read inside the
//  grid runs setup, RAM read and read data before its result step; a read
//  outside the grid, an out-of-bound vote or the unused code skip to it.
//  A clear sweeps the RAM one cell a cycle (GRID_SIDE^2, 11025 by default).
//  After reset the same sweep runs before the first transaction is accepted.
//  A result waiting in the output register does not block new input; only
//  the final cycle of the next item waits for the output register to empty.
// ----------------------------------------------------------------------------
module hough_vote_accumulator_bloom_core #(
    parameter int VOTE_BOUND   = hvab_pkg::VOTE_BOUND_DEF,
    parameter int BLOOM_RADIUS = hvab_pkg::BLOOM_RADIUS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hvab_in_if.sink    i_in,
    hvab_out_if.source o_out
);
    import hvab_pkg::*;

    localparam int GRID_PAD   = VOTE_BOUND + BLOOM_RADIUS;
    localparam int GRID_SIDE  = 2 * GRID_PAD + 1;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int ROW_W      = $clog2(GRID_SIDE);
    localparam int OFF_W      = $clog2(2 * BLOOM_RADIUS + 2);
    localparam int WGT_W      = $clog2(BLOOM_RADIUS + 2);
    localparam int DIFF_W     = COORD_W + 1;

    localparam logic signed [DIFF_W-1:0] BOUND_S   = DIFF_W'(VOTE_BOUND);
    localparam logic [OFF_W-1:0]         R_OFF     = OFF_W'(BLOOM_RADIUS);
    localparam logic [OFF_W-1:0]         R1_OFF    = OFF_W'(BLOOM_RADIUS + 1);
    localparam logic [OFF_W-1:0]         SPAN_OFF  = OFF_W'(2 * BLOOM_RADIUS);
    localparam logic [ADDR_W-1:0]        SIDE_A    = ADDR_W'(GRID_SIDE);
    localparam logic [ADDR_W-1:0]        ROW_STEP  = ADDR_W'(GRID_SIDE - 2 * BLOOM_RADIUS);
    localparam logic [ADDR_W-1:0]        LAST_ADDR = ADDR_W'(GRID_CELLS - 1);

    t_state r_state, n_state;

    logic [1:0]         r_func;
    logic               r_ok;
    logic               r_clr_reply;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_col;
    logic [ADDR_W-1:0]  r_addr;
    logic [OFF_W-1:0]   r_i;
    logic [OFF_W-1:0]   r_j;
    logic               r_wb_pend;
    logic [ADDR_W-1:0]  r_wb_addr;
    logic [WGT_W-1:0]   r_wb_w;
    logic [CELL_W-1:0]  r_res_value;
    logic               r_res_taken;
    logic               r_out_valid;
    logic [CELL_W-1:0]  r_out_value;
    logic               r_out_taken;

    logic               w_accept;
    logic               w_out_free;
    logic               w_vote_last;
    logic               w_clear_last;
    logic signed [DIFF_W-1:0] w_vx;
    logic signed [DIFF_W-1:0] w_vy;
    logic               w_in_bound;
    logic               w_in_range;
    logic [OFF_W-1:0]   w_ar;
    logic [OFF_W-1:0]   w_ac;
    logic [OFF_W-1:0]   w_dist;
    logic [WGT_W-1:0]   w_weight;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [CELL_W-1:0]  w_wdata;
    logic               w_re;
    logic [CELL_W-1:0]  w_rdata;

    hvab_ram #(
        .WIDTH (CELL_W),
        .DEPTH (GRID_CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Vote vector and range checks on the incoming item.
    assign w_vx = $signed({i_in.data.scan_x[COORD_W-1], i_in.data.scan_x})
                - $signed({i_in.data.tmpl_x[COORD_W-1], i_in.data.tmpl_x});
    assign w_vy = $signed({i_in.data.scan_y[COORD_W-1], i_in.data.scan_y})
                - $signed({i_in.data.tmpl_y[COORD_W-1], i_in.data.tmpl_y});
    assign w_in_bound = (w_vx < BOUND_S) && (w_vx > -BOUND_S)
                     && (w_vy < BOUND_S) && (w_vy > -BOUND_S);
    assign w_in_range = (32'(i_in.data.read_row) < 32'(GRID_SIDE))
                     && (32'(i_in.data.read_col) < 32'(GRID_SIDE));

    // Bloom weight falls off with the Chebyshev distance from the centre.
    assign w_ar     = (r_i >= R_OFF) ? (r_i - R_OFF) : (R_OFF - r_i);
    assign w_ac     = (r_j >= R_OFF) ? (r_j - R_OFF) : (R_OFF - r_j);
    assign w_dist   = (w_ar > w_ac) ? w_ar : w_ac;
    assign w_weight = WGT_W'(R1_OFF - w_dist);

    assign w_accept     = i_in.valid && i_in.ready;
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_vote_last  = (r_i == SPAN_OFF) && (r_j == SPAN_OFF);
    assign w_clear_last = (r_addr == LAST_ADDR);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (w_clear_last) begin
                    n_state = r_clr_reply ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in.valid) begin
                    unique case (i_in.data.func)
                        FUNC_CLEAR: n_state = ST_CLEAR;
                        FUNC_VOTE:  n_state = w_in_bound ? ST_SETUP : ST_FINISH;
                        FUNC_READ:  n_state = w_in_range ? ST_SETUP : ST_FINISH;
                        default:    n_state = ST_FINISH;
                    endcase
                end
            end
            ST_SETUP:     n_state = (r_func == FUNC_VOTE) ? ST_VOTE : ST_READ;
            ST_VOTE:      n_state = w_vote_last ? ST_TAIL : ST_VOTE;
            ST_TAIL:      n_state = ST_FINISH;
            ST_READ:      n_state = ST_READ_DATA;
            ST_READ_DATA: n_state = ST_FINISH;
            ST_FINISH:    n_state = w_out_free ? ST_IDLE : ST_FINISH;
            default:      n_state = ST_IDLE;
        endcase
    end

    // RAM port controls and input ready.
    always_comb begin
        i_in.ready = 1'b0;
        w_re       = 1'b0;
        w_we       = r_wb_pend;
        w_waddr    = r_wb_addr;
        w_wdata    = w_rdata + CELL_W'(r_wb_w);
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = '0;
            end
            ST_IDLE:      i_in.ready = 1'b1;
            ST_VOTE:      w_re       = 1'b1;
            ST_READ:      w_re       = 1'b1;
            ST_SETUP, ST_TAIL, ST_READ_DATA, ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_clr_reply <= 1'b0;
            r_wb_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
        end else begin
            r_state   <= n_state;
            r_wb_pend <= (r_state == ST_VOTE);

            if ((r_state == ST_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_addr <= w_clear_last ? '0 : r_addr + 1'b1;
                end
                ST_IDLE: begin
                    if (w_accept && (i_in.data.func == FUNC_CLEAR)) begin
                        r_addr      <= '0;
                        r_clr_reply <= 1'b1;
                    end
                end
                ST_SETUP: begin
                    // Top-left corner of the bloom, or the cell to read.
                    r_addr <= ADDR_W'(r_row) * SIDE_A + ADDR_W'(r_col);
                    r_i    <= '0;
                    r_j    <= '0;
                end
                ST_VOTE: begin
                    if (r_j == SPAN_OFF) begin
                        r_j    <= '0;
                        r_i    <= r_i + 1'b1;
                        r_addr <= r_addr + ROW_STEP;
                    end else begin
                        r_j    <= r_j + 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_TAIL, ST_READ, ST_READ_DATA, ST_FINISH: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func      <= i_in.data.func;
            r_res_value <= '0;
            r_res_taken <= (i_in.data.func == FUNC_VOTE) && w_in_bound;
            if (i_in.data.func == FUNC_VOTE) begin
                r_ok  <= w_in_bound;
                r_row <= ROW_W'(w_vy + BOUND_S);
                r_col <= ROW_W'(w_vx + BOUND_S);
            end else begin
                r_ok  <= w_in_range;
                r_row <= ROW_W'(i_in.data.read_row);
                r_col <= ROW_W'(i_in.data.read_col);
            end
        end
        if (r_state == ST_VOTE) begin
            r_wb_addr <= r_addr;
            r_wb_w    <= w_weight;
        end
        if ((r_state == ST_READ_DATA) && r_ok) begin
            r_res_value <= w_rdata;
        end
        if ((r_state == ST_FINISH) && w_out_free) begin
            r_out_value <= r_res_value;
            r_out_taken <= r_res_taken;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.data.cell_value = r_out_value;
    assign o_out.data.vote_taken = r_out_taken;
endmodule
`default_nettype wire

// ----- src/hvab_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hvab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hough vote accumulator testbench
// Drives clear, vote, read and unused-code commands through the command
// channel, keeps its own copy of the vote grid to predict each result, and
// checks every result transaction field by field. Both channels idle and
// stall at random, and the run also holds off the result side for a long
// stretch and drains the block completely before some commands.
// ----------------------------------------------------------------------------
module tb;
    import hvab_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int GRID_PAD      = VOTE_BOUND_DEF + BLOOM_RADIUS_DEF;
    localparam int GRID_SIDE     = 2 * GRID_PAD + 1;
    localparam int GRID_CELLS    = GRID_SIDE * GRID_SIDE;
    localparam int COORD_MIN     = -(1 << (COORD_W - 1));
    localparam int COORD_MAX     = (1 << (COORD_W - 1)) - 1;
    localparam int PHASES        = 4;
    localparam int PHASE_CMDS    = 232;
    localparam int LONG_HOLD_AT  = 250;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 4 * (GRID_CELLS + LONG_HOLD + 200);
    localparam int MAX_REPORTS   = 10;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct {
        t_in_item cmd;
        bit       drain;
    } t_pending;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hvab_in_if  cmd_ch ();
    hvab_out_if res_ch ();

    hough_vote_accumulator_bloom_core #(
        .VOTE_BOUND   (VOTE_BOUND_DEF),
        .BLOOM_RADIUS (BLOOM_RADIUS_DEF)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    logic [CELL_W-1:0] vote_cells [GRID_CELLS];
    t_pending          pending [$];
    t_out_item         results_due [$];

    int  cmd_offered   = 0;
    int  cmd_accepted  = 0;
    int  total_cmds    = 0;
    int  results_seen  = 0;
    int  err_cnt       = 0;
    int  idle_cycles   = 0;
    int  gap_left      = 0;
    int  hold_left     = 0;
    bit  long_hold_done = 1'b0;
    int  n_taken = 0, n_rejected = 0, n_reads = 0, n_hits = 0;
    int  n_clears = 0, n_spare = 0;
    logic calm_stretch;

    // Every third block of a hundred commands runs with no idling on either side.
    assign calm_stretch = ((cmd_accepted / 100) % 3) == 1;

    function automatic void log_error(string msg);
        if (err_cnt < MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
        err_cnt++;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        if (r < 98) return int'($urandom_range(4, 15));
        return int'($urandom_range(30, 120));
    endfunction

    // Applies one command to the shadow grid and returns the result it yields.
    function automatic t_out_item tally_command(t_in_item c);
        t_out_item res;
        int vx, vy, row, col, ar, ac, w;
        res = '0;
        case (c.func)
            FUNC_CLEAR: begin
                foreach (vote_cells[i]) vote_cells[i] = '0;
                n_clears++;
            end
            FUNC_VOTE: begin
                vx = int'($signed(c.scan_x)) - int'($signed(c.tmpl_x));
                vy = int'($signed(c.scan_y)) - int'($signed(c.tmpl_y));
                if (vx < VOTE_BOUND_DEF && vx > -VOTE_BOUND_DEF &&
                    vy < VOTE_BOUND_DEF && vy > -VOTE_BOUND_DEF) begin
                    for (int dr = -BLOOM_RADIUS_DEF; dr <= BLOOM_RADIUS_DEF; dr++) begin
                        for (int dc = -BLOOM_RADIUS_DEF; dc <= BLOOM_RADIUS_DEF; dc++) begin
                            ar  = (dr < 0) ? -dr : dr;
                            ac  = (dc < 0) ? -dc : dc;
                            w   = BLOOM_RADIUS_DEF + 1 - ((ar > ac) ? ar : ac);
                            row = vy + dr + GRID_PAD;
                            col = vx + dc + GRID_PAD;
                            if (row >= 0 && row < GRID_SIDE && col >= 0 && col < GRID_SIDE)
                                vote_cells[row * GRID_SIDE + col] += CELL_W'(w);
                        end
                    end
                    res.vote_taken = 1'b1;
                    n_taken++;
                end else begin
                    n_rejected++;
                end
            end
            FUNC_READ: begin
                n_reads++;
                if (c.read_row < GRID_SIDE && c.read_col < GRID_SIDE)
                    res.cell_value = vote_cells[c.read_row * GRID_SIDE + c.read_col];
                if (res.cell_value != '0)
                    n_hits++;
            end
            default: n_spare++;
        endcase
        return res;
    endfunction

    // Builds a vote whose vector is (vx, vy), with the template point placed at
    // random wherever both points still fit the coordinate range.
    function automatic t_in_item make_vote(int vx, int vy);
        t_in_item c;
        int lo, hi, tx, ty;
        c      = {$urandom, $urandom};
        c.func = FUNC_VOTE;
        lo = (vx > 0) ? COORD_MIN : COORD_MIN - vx;
        hi = (vx > 0) ? COORD_MAX - vx : COORD_MAX;
        tx = lo + int'($urandom_range(hi - lo));
        lo = (vy > 0) ? COORD_MIN : COORD_MIN - vy;
        hi = (vy > 0) ? COORD_MAX - vy : COORD_MAX;
        ty = lo + int'($urandom_range(hi - lo));
        c.tmpl_x = COORD_W'(tx);
        c.scan_x = COORD_W'(tx + vx);
        c.tmpl_y = COORD_W'(ty);
        c.scan_y = COORD_W'(ty + vy);
        return c;
    endfunction

    function automatic t_in_item make_read(int row, int col);
        t_in_item c;
        c          = {$urandom, $urandom};
        c.func     = FUNC_READ;
        c.read_row = INDEX_W'(row);
        c.read_col = INDEX_W'(col);
        return c;
    endfunction

    function automatic t_in_item make_other(logic [1:0] code);
        t_in_item c;
        c      = {$urandom, $urandom};
        c.func = code;
        return c;
    endfunction

    function automatic void queue_cmd(t_in_item c, bit drain);
        pending.insert(pending.size(), t_pending'{c, drain});
    endfunction

    // Command side: offers the next pending command after a random gap.
    always @(negedge i_clk) begin
        if (i_rst_n && (!cmd_ch.valid || cmd_accepted == cmd_offered)) begin
            if (gap_left > 0) begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end else if (pending.size() != 0 &&
                         !(pending[0].drain && results_due.size() != 0)) begin
                cmd_ch.data  <= pending[0].cmd;
                cmd_ch.valid <= 1'b1;
                pending.pop_front();
                cmd_offered++;
                gap_left = calm_stretch ? 0 : pick_gap();
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off while commands keep
    // arriving, so that the block backs up and stalls its command input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (!long_hold_done && cmd_accepted >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            res_ch.ready  <= 1'b0;
        end else if (calm_stretch) begin
            res_ch.ready <= 1'b1;
        end else begin
            hold_left = pick_gap();
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: results are checked before the command of the same edge is
    // predicted, since a result always belongs to an older transaction.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        bit        cmd_fire;
        bit        res_fire;
        if (i_rst_n) begin
            cmd_fire = cmd_ch.valid && cmd_ch.ready;
            res_fire = res_ch.valid && res_ch.ready;
            if (res_fire) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    log_error($sformatf("result with nothing outstanding: value %0h taken %0b",
                                        res_ch.data.cell_value, res_ch.data.vote_taken));
                end else begin
                    want = results_due.pop_front();
                    if (res_ch.data.cell_value !== want.cell_value)
                        log_error($sformatf("result %0d cell_value: expected %0h, got %0h",
                                            results_seen, want.cell_value,
                                            res_ch.data.cell_value));
                    if (res_ch.data.vote_taken !== want.vote_taken)
                        log_error($sformatf("result %0d vote_taken: expected %0b, got %0b",
                                            results_seen, want.vote_taken,
                                            res_ch.data.vote_taken));
                end
            end
            if (cmd_fire) begin
                results_due.insert(results_due.size(), tally_command(cmd_ch.data));
                cmd_accepted++;
            end
            if (cmd_fire || res_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        t_in_item c;
        int       hot_vx [4];
        int       hot_vy [4];
        int       recent_row [$];
        int       recent_col [$];
        int       r, k, vx, vy;

        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;
        foreach (vote_cells[i]) vote_cells[i] = '0;

        // Directed commands: bloom weights, bound edges, coordinate extremes,
        // reads outside the grid, the unused code and a clear.
        queue_cmd(make_read(0, 0), 1'b0);
        queue_cmd(make_vote(0, 0), 1'b0);
        queue_cmd(make_read(GRID_PAD, GRID_PAD), 1'b0);
        queue_cmd(make_read(GRID_PAD - 1, GRID_PAD + 1), 1'b0);
        queue_cmd(make_read(GRID_PAD + 2, GRID_PAD - 2), 1'b0);
        queue_cmd(make_read(GRID_PAD + 3, GRID_PAD), 1'b0);
        queue_cmd(make_vote(-(VOTE_BOUND_DEF - 1), -(VOTE_BOUND_DEF - 1)), 1'b0);
        queue_cmd(make_read(1, 1), 1'b0);
        queue_cmd(make_vote(VOTE_BOUND_DEF - 1, VOTE_BOUND_DEF - 1), 1'b0);
        queue_cmd(make_read(GRID_SIDE - 2, GRID_SIDE - 2), 1'b0);
        queue_cmd(make_read(GRID_SIDE - 1, GRID_SIDE - 1), 1'b0);
        queue_cmd(make_vote(COORD_MAX - COORD_MIN, 0), 1'b0);
        queue_cmd(make_vote(COORD_MIN - COORD_MAX, COORD_MIN - COORD_MAX), 1'b0);
        queue_cmd(make_vote(0, COORD_MAX - COORD_MIN), 1'b0);
        queue_cmd(make_vote(VOTE_BOUND_DEF, 0), 1'b0);
        queue_cmd(make_vote(0, -VOTE_BOUND_DEF), 1'b0);
        queue_cmd(make_vote(-VOTE_BOUND_DEF, VOTE_BOUND_DEF - 1), 1'b0);
        queue_cmd(make_vote(VOTE_BOUND_DEF - 1, -(VOTE_BOUND_DEF - 1)), 1'b0);
        queue_cmd(make_read(GRID_SIDE, 0), 1'b0);
        queue_cmd(make_read(0, 127), 1'b0);
        queue_cmd(make_read(127, 127), 1'b0);
        queue_cmd(make_other(FUNC_SPARE), 1'b0);
        queue_cmd(make_read(GRID_PAD, GRID_PAD), 1'b0);
        queue_cmd(make_other(FUNC_CLEAR), 1'b1);
        queue_cmd(make_read(GRID_PAD, GRID_PAD), 1'b0);

        // Random phases: votes cluster on a few hot vectors so that cells
        // build up, and most reads land near recent vote centres.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0)
                queue_cmd(make_other(FUNC_CLEAR), 1'b1);
            foreach (hot_vx[i]) begin
                hot_vx[i] = int'($urandom_range(0, 98)) - (VOTE_BOUND_DEF - 1);
                hot_vy[i] = int'($urandom_range(0, 98)) - (VOTE_BOUND_DEF - 1);
                if ($urandom_range(0, 4) == 0)
                    hot_vx[i] = ($urandom_range(0, 1) != 0) ? VOTE_BOUND_DEF - 1
                                                            : -(VOTE_BOUND_DEF - 1);
            end
            for (int n = 0; n < PHASE_CMDS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    if ($urandom_range(0, 1) != 0) begin
                        k  = $urandom_range(0, 3);
                        vx = hot_vx[k];
                        vy = hot_vy[k];
                    end else begin
                        vx = int'($urandom_range(0, 98)) - (VOTE_BOUND_DEF - 1);
                        vy = int'($urandom_range(0, 98)) - (VOTE_BOUND_DEF - 1);
                    end
                    c = make_vote(vx, vy);
                    recent_row.insert(recent_row.size(), vy + GRID_PAD);
                    recent_col.insert(recent_col.size(), vx + GRID_PAD);
                    if (recent_row.size() > 16) begin
                        recent_row.pop_front();
                        recent_col.pop_front();
                    end
                end else if (r < 53) begin
                    vx = int'($urandom_range(VOTE_BOUND_DEF, VOTE_BOUND_DEF + 10));
                    if ($urandom_range(0, 1) != 0) vx = -vx;
                    vy = int'($urandom_range(0, 120)) - 60;
                    c  = ($urandom_range(0, 1) != 0) ? make_vote(vx, vy) : make_vote(vy, vx);
                end else if (r < 56) begin
                    c = make_other(FUNC_VOTE);
                end else if (r < 88 && recent_row.size() != 0) begin
                    k = $urandom_range(0, recent_row.size() - 1);
                    c = make_read(recent_row[k] + int'($urandom_range(0, 6)) - 3,
                                  recent_col[k] + int'($urandom_range(0, 6)) - 3);
                end else if (r < 91) begin
                    c = make_other(FUNC_SPARE);
                end else if (r < 92) begin
                    c = make_other(FUNC_CLEAR);
                end else begin
                    c = make_read($urandom_range(0, 127), $urandom_range(0, 127));
                end
                queue_cmd(c, $urandom_range(0, 49) == 0);
            end
        end
        total_cmds = pending.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || cmd_accepted != total_cmds)
            @(posedge i_clk);
        while (results_due.size() != 0)
            @(posedge i_clk);
        // Keep running afterwards so that any stray result would still be caught.
        repeat (40) @(posedge i_clk);

        $display("Run: %0d votes, %0d rejected, %0d reads (%0d hit), %0d clears, %0d spare",
                 n_taken, n_rejected, n_reads, n_hits, n_clears, n_spare);
        $display("Results checked: %0d, mismatches: %0d", results_seen, err_cnt);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
